// ===== design/sm4_pkg.sv =====
`timescale 1ns / 1ps

package sm4_pkg;

   localparam int NUM_ROUNDS  = 32;
   localparam int ROUND_W     = 5;
   localparam int WORD_W      = 32;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] REG_KEY_HIGH = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_LOW  = 8'd1;

   localparam logic [WORD_W-1:0] FK [4] = '{
      32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
   };

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   typedef struct packed {
      logic        kind;
      logic [63:0] block_high;
      logic [63:0] block_low;
   } sm4_req_payload_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } sm4_rsp_payload_type;

   typedef struct packed {
      logic                  kind;
      logic [3:0][WORD_W-1:0] words;
   } sm4_data_type;

   typedef struct packed {
      logic         valid;
      sm4_data_type data;
   } sm4_stage_type;

   typedef struct packed {
      logic               active;
      logic [ROUND_W-1:0] round;
   } sm4_key_status_type;

   function automatic logic [WORD_W-1:0] subst_word(input logic [WORD_W-1:0] x);
      subst_word = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
   endfunction

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
      rotl = (x << n) | (x >> (WORD_W - n));
   endfunction

   function automatic logic [WORD_W-1:0] lin_data(input logic [WORD_W-1:0] x);
      lin_data = x ^ rotl(x, 2) ^ rotl(x, 10) ^ rotl(x, 18) ^ rotl(x, 24);
   endfunction

   function automatic logic [WORD_W-1:0] lin_key(input logic [WORD_W-1:0] x);
      lin_key = x ^ rotl(x, 13) ^ rotl(x, 23);
   endfunction

   // byte j of CK[i] is (4i + j) * 7 mod 256, taken as 8x - x
   function automatic logic [WORD_W-1:0] ck_word(input logic [ROUND_W-1:0] i);
      logic [7:0] idx;
      logic [WORD_W-1:0] w;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         idx = {1'b0, i, 2'(j)};
         w   = {w[23:0], 8'((idx << 3) - idx)};
      end
      ck_word = w;
   endfunction

endpackage

// ===== design/sm4_key_expand.sv =====
`timescale 1ns / 1ps

module sm4_key_expand
   import sm4_pkg::*;
(
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [CSR_INDEX_W-1:0]              csr_index,
   input  logic [CSR_DATA_W-1:0]               csr_write_data,
   output logic [NUM_ROUNDS-1:0][WORD_W-1:0]   round_keys,
   output sm4_key_status_type                  status
);

   logic [63:0]             key_high_ff, key_high_in;
   logic [63:0]             key_low_ff, key_low_in;
   logic [3:0][WORD_W-1:0]  k_ff, k_in;
   logic                    active_ff, active_in;
   logic [ROUND_W-1:0]      round_ff, round_in;
   logic                    restart;
   logic [WORD_W-1:0]       t;
   logic [WORD_W-1:0]       nk;
   logic [NUM_ROUNDS-1:0][WORD_W-1:0] rk_ff;

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      restart     = 1'b0;
      if (csr_write_en && csr_index == REG_KEY_HIGH) begin
         key_high_in = csr_write_data;
         restart     = 1'b1;
      end else if (csr_write_en && csr_index == REG_KEY_LOW) begin
         key_low_in = csr_write_data;
         restart    = 1'b1;
      end

      t  = k_ff[1] ^ k_ff[2] ^ k_ff[3] ^ ck_word(round_ff);
      nk = k_ff[0] ^ lin_key(subst_word(t));

      k_in      = k_ff;
      round_in  = round_ff;
      active_in = active_ff;
      if (restart) begin
         k_in[0]   = key_high_in[63:32] ^ FK[0];
         k_in[1]   = key_high_in[31:0]  ^ FK[1];
         k_in[2]   = key_low_in[63:32]  ^ FK[2];
         k_in[3]   = key_low_in[31:0]   ^ FK[3];
         round_in  = '0;
         active_in = 1'b1;
      end else if (active_ff) begin
         k_in      = {nk, k_ff[3], k_ff[2], k_ff[1]};
         round_in  = round_ff + 1'b1;
         active_in = (round_ff != ROUND_W'(NUM_ROUNDS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         k_ff        <= {FK[3], FK[2], FK[1], FK[0]};
         round_ff    <= '0;
         active_ff   <= 1'b1;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
         k_ff        <= k_in;
         round_ff    <= round_in;
         active_ff   <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!reset && active_ff && !restart) begin
         rk_ff[round_ff] <= nk;
      end
   end

   assign round_keys    = rk_ff;
   assign status.active = active_ff;
   assign status.round  = round_ff;

endmodule

// ===== design/sm4_round.sv =====
`timescale 1ns / 1ps

module sm4_round
   import sm4_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  sm4_stage_type stage_in,
   input  logic [WORD_W-1:0] rk_enc,
   input  logic [WORD_W-1:0] rk_dec,
   output sm4_stage_type stage_out
);

   logic              valid_ff;
   sm4_data_type      data_ff, data_in;
   logic [WORD_W-1:0] rk;
   logic [WORD_W-1:0] nx;

   always_comb begin
      rk = stage_in.data.kind ? rk_dec : rk_enc;
      nx = stage_in.data.words[0] ^ lin_data(subst_word(stage_in.data.words[1] ^
           stage_in.data.words[2] ^ stage_in.data.words[3] ^ rk));
      data_in.kind  = stage_in.data.kind;
      data_in.words = {nx, stage_in.data.words[3], stage_in.data.words[2],
                       stage_in.data.words[1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.data  = data_ff;

endmodule

// ===== design/sm4_block_cipher_top.sv =====
`timescale 1ns / 1ps

// channel   ports                                        transaction taken when
// request   start, busy, req_payload                     start && !busy
// response  rsp_strobe, rsp_payload                      rsp_strobe (one cycle)
// config    csr_write_en, csr_index, csr_write_data      csr_write_en
//
// One round per pipeline stage, 32 stages: a block accepted with start && !busy
// moves through every stage register to the response ports; one block per cycle
// while busy is low. Reset and every key write start the key schedule, one round
// key per cycle; busy is high until the last round key is written. The receiver
// cannot stall, so the pipeline always advances.

module sm4_block_cipher_top
   import sm4_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  sm4_req_payload_type    req_payload,
   output logic                   rsp_strobe,
   output sm4_rsp_payload_type    rsp_payload,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic [NUM_ROUNDS-1:0][WORD_W-1:0] round_keys;
   sm4_key_status_type                key_status;
   sm4_stage_type                     stage [NUM_ROUNDS+1];
   logic                              accept;

   sm4_key_expand u_key_expand (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .round_keys     (round_keys),
      .status         (key_status)
   );

   assign busy   = key_status.active;
   assign accept = start && !busy;

   assign stage[0].valid          = accept;
   assign stage[0].data.kind      = req_payload.kind;
   assign stage[0].data.words[0]  = req_payload.block_high[63:32];
   assign stage[0].data.words[1]  = req_payload.block_high[31:0];
   assign stage[0].data.words[2]  = req_payload.block_low[63:32];
   assign stage[0].data.words[3]  = req_payload.block_low[31:0];

   for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_round
      sm4_round u_round (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (stage[i]),
         .rk_enc    (round_keys[i]),
         .rk_dec    (round_keys[NUM_ROUNDS-1-i]),
         .stage_out (stage[i+1])
      );
   end

   assign rsp_strobe              = stage[NUM_ROUNDS].valid;
   assign rsp_payload.result_high = {stage[NUM_ROUNDS].data.words[3],
                                     stage[NUM_ROUNDS].data.words[2]};
   assign rsp_payload.result_low  = {stage[NUM_ROUNDS].data.words[1],
                                     stage[NUM_ROUNDS].data.words[0]};

`ifndef NO_ASSERTIONS
   a_rsp_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, NUM_ROUNDS))
      else $error("response without a matching request");

   a_key_write_busy: assert property (@(posedge clock) disable iff (reset)
      (csr_write_en && (csr_index == REG_KEY_HIGH || csr_index == REG_KEY_LOW)) |=> busy)
      else $error("key write did not start the key schedule");

   a_schedule_length: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(key_status.round) == ROUND_W'(NUM_ROUNDS - 1))
      else $error("key schedule ended early");
`endif

endmodule
